// ===== hw/rtl/tbw_pkg.sv =====
// Package: widths and register indexes for the barycentric weights core.
`timescale 1ns / 1ps
package tbw_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 12;
    localparam int WEIGHT_W    = 16;
    localparam int INT_BITS    = WEIGHT_W - FRAC_BITS;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int AREA_W      = 2 * COORD_WIDTH + 3;
    localparam int WIDE_W      = AREA_W + WEIGHT_W;
    localparam int CFG_IDX_W   = 3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_B_X = 3'd2,
        REG_B_Y = 3'd3,
        REG_C_X = 3'd4,
        REG_C_Y = 3'd5
    } cfg_idx_t;
endpackage

// ===== hw/rtl/triangle_barycentric_weights_core.sv =====
// Top level: pipelined barycentric weights of a point against a fixed triangle.
`timescale 1ns / 1ps
// One item (a query point) enters per cycle when the output is not stalled,
// and passes through one stage each for the edge differences, the 17x17
// products and the absolute cross products, one for the saturation check and
// divider set-up, sixteen restoring divider stages (one quotient bit each, three
// lanes side by side), and the output register. The whole pipeline advances
// together; a stall at the output holds every stage. Vertices must be written
// through the cfg port while the block is idle; the block does not enforce this.
// They take effect for the next item accepted. Weights are unsigned Q4.12,
// truncated; a zero-area triangle gives zero weights with degenerate set, and a
// weight of sixteen or more clips to 65535 with saturated set.
module triangle_barycentric_weights_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [tbw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tbw_pkg::COORD_WIDTH-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [tbw_pkg::COORD_WIDTH-1:0] s_point_x,
    input  logic signed [tbw_pkg::COORD_WIDTH-1:0] s_point_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tbw_pkg::WEIGHT_W-1:0]         m_weight_a,
    output logic [tbw_pkg::WEIGHT_W-1:0]         m_weight_b,
    output logic [tbw_pkg::WEIGHT_W-1:0]         m_weight_c,
    output logic                                 m_degenerate,
    output logic                                 m_saturated
);
    localparam int CW = tbw_pkg::COORD_WIDTH;
    localparam int DW = tbw_pkg::DIFF_W;
    localparam int PW = tbw_pkg::PROD_W;
    localparam int AW = tbw_pkg::AREA_W;
    localparam int WW = tbw_pkg::WEIGHT_W;
    localparam int XW = tbw_pkg::WIDE_W;
    localparam int NDIV = WW;

    // vertex registers
    logic signed [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg <= '0; ay_reg <= '0; bx_reg <= '0;
            by_reg <= '0; cx_reg <= '0; cy_reg <= '0;
        end else if (cfg_wr_en) begin
            case (tbw_pkg::cfg_idx_t'(cfg_index))
                tbw_pkg::REG_A_X: ax_reg <= cfg_data;
                tbw_pkg::REG_A_Y: ay_reg <= cfg_data;
                tbw_pkg::REG_B_X: bx_reg <= cfg_data;
                tbw_pkg::REG_B_Y: by_reg <= cfg_data;
                tbw_pkg::REG_C_X: cx_reg <= cfg_data;
                tbw_pkg::REG_C_Y: cy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the output register is free or being emptied
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // lane 0 is the full triangle, lanes 1..3 the sub-triangles opposite a, b, c
    logic signed [CW-1:0] ox [4], oy [4], ux1 [4], uy1 [4], ux2 [4], uy2 [4];
    always_comb begin
        ox[0] = ax_reg;    oy[0] = ay_reg;
        ux1[0] = bx_reg;   uy1[0] = by_reg;   ux2[0] = cx_reg; uy2[0] = cy_reg;
        ox[1] = s_point_x; oy[1] = s_point_y;
        ux1[1] = bx_reg;   uy1[1] = by_reg;   ux2[1] = cx_reg; uy2[1] = cy_reg;
        ox[2] = s_point_x; oy[2] = s_point_y;
        ux1[2] = ax_reg;   uy1[2] = ay_reg;   ux2[2] = cx_reg; uy2[2] = cy_reg;
        ox[3] = s_point_x; oy[3] = s_point_y;
        ux1[3] = ax_reg;   uy1[3] = ay_reg;   ux2[3] = bx_reg; uy2[3] = by_reg;
    end

    // stage 1: differences
    logic                 v1_reg;
    logic signed [DW-1:0] dx1_reg [4], dy1_reg [4], dx2_reg [4], dy2_reg [4];
    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] pa_reg [4], pb_reg [4];
    // stage 3: absolute areas
    logic                 v3_reg;
    logic [AW-1:0]        area_reg [4];
    // divider stages, index 0 is set-up
    logic                 dv_reg  [NDIV+1];
    logic [AW-1:0]        den_reg [NDIV+1];
    logic                 deg_reg [NDIV+1];
    logic [AW-1:0]        rem_reg [NDIV+1][3];
    logic [WW-1:0]        low_reg [NDIV+1][3];
    logic [WW-1:0]        quo_reg [NDIV+1][3];
    logic                 sat_reg [NDIV+1][3];

    logic [AW-1:0]        rem_next [NDIV+1][3];
    logic [WW-1:0]        quo_next [NDIV+1][3];
    logic [WW-1:0]        low_next [NDIV+1][3];

    // one restoring step per stage: shift in the next dividend bit
    always_comb begin
        logic [AW:0] rs;
        for (int s = 1; s <= NDIV; s++) begin
            for (int l = 0; l < 3; l++) begin
                rs = {rem_reg[s-1][l], low_reg[s-1][l][WW-1]};
                low_next[s][l] = {low_reg[s-1][l][WW-2:0], 1'b0};
                if (rs >= {1'b0, den_reg[s-1]}) begin
                    rem_next[s][l] = AW'(rs - {1'b0, den_reg[s-1]});
                    quo_next[s][l] = {quo_reg[s-1][l][WW-2:0], 1'b1};
                end else begin
                    rem_next[s][l] = AW'(rs);
                    quo_next[s][l] = {quo_reg[s-1][l][WW-2:0], 1'b0};
                end
            end
        end
        for (int l = 0; l < 3; l++) begin
            rem_next[0][l] = '0;
            quo_next[0][l] = '0;
            low_next[0][l] = '0;
        end
    end

    // valid chain, cleared on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            for (int s = 0; s <= NDIV; s++) dv_reg[s] <= 1'b0;
            m_valid <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            dv_reg[0] <= v3_reg;
            for (int s = 1; s <= NDIV; s++) dv_reg[s] <= dv_reg[s-1];
            m_valid <= dv_reg[NDIV];
        end
    end

    // payload path, no reset
    always_ff @(posedge aclk) begin
        logic signed [PW:0] cr;
        if (adv) begin
            for (int l = 0; l < 4; l++) begin
                dx1_reg[l] <= DW'(ux1[l]) - DW'(ox[l]);
                dy1_reg[l] <= DW'(uy1[l]) - DW'(oy[l]);
                dx2_reg[l] <= DW'(ux2[l]) - DW'(ox[l]);
                dy2_reg[l] <= DW'(uy2[l]) - DW'(oy[l]);
                pa_reg[l]  <= dx1_reg[l] * dy2_reg[l];
                pb_reg[l]  <= dy1_reg[l] * dx2_reg[l];
                cr = (PW+1)'(pa_reg[l]) - (PW+1)'(pb_reg[l]);
                area_reg[l] <= cr[PW] ? AW'(-cr) : AW'(cr);
            end
            // set-up: saturate when area >= total * 2^INT_BITS
            den_reg[0] <= area_reg[0];
            deg_reg[0] <= (area_reg[0] == '0);
            for (int l = 0; l < 3; l++) begin
                sat_reg[0][l] <= (XW'(area_reg[l+1]) >=
                                  (XW'(area_reg[0]) << tbw_pkg::INT_BITS));
                rem_reg[0][l] <= AW'(area_reg[l+1] >> tbw_pkg::INT_BITS);
                low_reg[0][l] <= WW'(XW'(area_reg[l+1]) << tbw_pkg::FRAC_BITS);
                quo_reg[0][l] <= quo_next[0][l];
            end
            for (int s = 1; s <= NDIV; s++) begin
                den_reg[s] <= den_reg[s-1];
                deg_reg[s] <= deg_reg[s-1];
                for (int l = 0; l < 3; l++) begin
                    sat_reg[s][l] <= sat_reg[s-1][l];
                    rem_reg[s][l] <= rem_next[s][l];
                    low_reg[s][l] <= low_next[s][l];
                    quo_reg[s][l] <= quo_next[s][l];
                end
            end
            // output register
            m_degenerate <= deg_reg[NDIV];
            m_saturated  <= !deg_reg[NDIV] &&
                            (sat_reg[NDIV][0] || sat_reg[NDIV][1] || sat_reg[NDIV][2]);
            m_weight_a <= deg_reg[NDIV] ? '0 :
                          sat_reg[NDIV][0] ? tbw_pkg::WEIGHT_MAX : quo_reg[NDIV][0];
            m_weight_b <= deg_reg[NDIV] ? '0 :
                          sat_reg[NDIV][1] ? tbw_pkg::WEIGHT_MAX : quo_reg[NDIV][1];
            m_weight_c <= deg_reg[NDIV] ? '0 :
                          sat_reg[NDIV][2] ? tbw_pkg::WEIGHT_MAX : quo_reg[NDIV][2];
        end
    end

    // checks
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            m_weight_a == '0 && m_weight_b == '0 && m_weight_c == '0)
        else $error("degenerate result with nonzero weight");
    a_deg_nosat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> !m_saturated)
        else $error("degenerate and saturated together");
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_weight_a == tbw_pkg::WEIGHT_MAX ||
            m_weight_b == tbw_pkg::WEIGHT_MAX || m_weight_c == tbw_pkg::WEIGHT_MAX)
        else $error("saturated without a clipped weight");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(dv_reg[NDIV]) && $stable(quo_reg[NDIV][0]))
        else $error("pipeline moved during stall");
endmodule
